@@ rtl/mf3_pkg.sv @@
// Shared types and constants for the 3x3 RGB median filter.
// No dependencies; every other file in rtl/ imports this package.
package mf3_pkg;

	// One color component.
	typedef logic [7:0] chan_t;

	// Input item: one RGB pixel.
	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} pixel_t;

	// Output widths of the window center position.
	localparam int ROW_OUT_W = 12;
	localparam int COL_OUT_W = 11;

	// Position data that travels alongside a window through the pipeline.
	typedef struct packed {
		logic [ROW_OUT_W-1:0] center_row;
		logic [COL_OUT_W-1:0] center_col;
		logic                 frame_last;
	} meta_t;

	// Output item: three medians plus the window center position.
	typedef struct packed {
		chan_t                out_blue;
		chan_t                out_green;
		chan_t                out_red;
		logic [ROW_OUT_W-1:0] center_row;
		logic [COL_OUT_W-1:0] center_col;
		logic                 frame_last;
	} result_t;

	// 3x3 window, index = window row * 3 + window column, column 2 newest.
	localparam int WIN_SIZE = 9;
	typedef pixel_t [WIN_SIZE-1:0] win_pix_t;
	typedef chan_t  [WIN_SIZE-1:0] win_chan_t;

	// Configuration register indexes and their reset values.
	localparam int CFG_DATA_W = 13;
	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;
	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;
	localparam int DIM_MIN    = 3;

	// Line buffer controls: an item is accepted, an item leaves stage 1.
	typedef struct packed {
		logic acc;
		logic shift;
	} lb_ctl_t;

	// Median lane stage load enables.
	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
	} lane_ctl_t;

endpackage

@@ rtl/median_filter_3x3_rgb.sv @@
// Streaming 3x3 median filter, RGB, three color lanes side by side.
// Path: a result passes stage 1, the window, the row sort, the trio register and the output register.
// Throughput: one pixel per cycle unless stalled; one read and one write per line memory per cycle.
// Reset: position returns to row 0, column 0, size to 640 x 480; line memories are not cleared.
// Any configuration write restarts the frame at row 0, column 0.
// Depends on mf3_pkg, mf3_line_buf and mf3_lane.
module median_filter_3x3_rgb #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  mf3_pkg::pixel_t                   pix,
	output logic                              res_valid,
	input  logic                              res_ready,
	output mf3_pkg::result_t                  res,
	input  logic                              cfg_we,
	input  mf3_pkg::cfg_reg_t                 cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mf3_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
	localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > 13) ? $clog2(MAX_HEIGHT + 1) : 13;
	localparam int COL_LAST_RST = ((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST) - 1;
	localparam int ROW_LAST_RST = ((HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST) - 1;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_last_q;
	logic [ROW_W-1:0] row_last_q;
	logic [COL_W-1:0] col_last_nx;
	logic [ROW_W-1:0] row_last_nx;
	logic [WCMP_W-1:0] w_ext;
	logic [HCMP_W-1:0] h_ext;

	logic  v_s1, v_s2, v_s3, v_s4, v_o;
	logic  emit_s1;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4;
	logic  rdy_s2, rdy_s3, rdy_s4, rdy_o;
	logic  acc, leave_s1;
	logic  at_col_end, at_row_end;
	result_t res_q;

	lb_ctl_t   lb_ctl;
	lane_ctl_t lane_ctl;
	win_pix_t  win;
	win_chan_t win_b, win_g, win_r;
	chan_t     med_b, med_g, med_r;

	// Clamp a written size to the supported range and keep the last index.
	always_comb begin
		w_ext = WCMP_W'(cfg_data[11:0]);
		h_ext = HCMP_W'(cfg_data[12:0]);
		if (w_ext < WCMP_W'(DIM_MIN)) begin
			col_last_nx = COL_W'(DIM_MIN - 1);
		end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
			col_last_nx = COL_W'(MAX_WIDTH - 1);
		end else begin
			col_last_nx = COL_W'(w_ext - 1'b1);
		end
		if (h_ext < HCMP_W'(DIM_MIN)) begin
			row_last_nx = ROW_W'(DIM_MIN - 1);
		end else if (h_ext > HCMP_W'(MAX_HEIGHT)) begin
			row_last_nx = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			row_last_nx = ROW_W'(h_ext - 1'b1);
		end
	end

	// Handshake chain: each stage takes a new item when empty or when it moves on.
	assign rdy_o     = !v_o || res_ready;
	assign rdy_s4    = !v_s4 || rdy_o;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign pix_ready = !v_s1 || rdy_s2;
	assign acc       = pix_valid && pix_ready;
	assign leave_s1  = v_s1 && rdy_s2;

	assign at_col_end = (col_q == col_last_q);
	assign at_row_end = (row_q == row_last_q);

	// Frame size registers and the raster position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= COL_W'(COL_LAST_RST);
			row_last_q <= ROW_W'(ROW_LAST_RST);
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  col_last_q <= col_last_nx;
				REG_IMAGE_HEIGHT: row_last_q <= row_last_nx;
				default:          col_last_q <= col_last_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (at_col_end) begin
				col_q <= '0;
				row_q <= at_row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Stage valid bits; only items that complete a window go past stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_o     <= 1'b0;
		end else begin
			if (pix_ready) begin
				v_s1    <= pix_valid;
				emit_s1 <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			end
			if (rdy_s2) v_s2 <= v_s1 && emit_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_o)  v_o  <= v_s4;
		end
	end

	// Window center position carried beside the data.
	always_ff @(posedge clk) begin
		if (acc) begin
			meta_s1.center_row <= ROW_OUT_W'(row_q - 1'b1);
			meta_s1.center_col <= COL_OUT_W'(col_q - 1'b1);
			meta_s1.frame_last <= at_col_end && at_row_end;
		end
		if (rdy_s2) meta_s2 <= meta_s1;
		if (rdy_s3) meta_s3 <= meta_s2;
		if (rdy_s4) meta_s4 <= meta_s3;
	end

	// Line memories and window.
	assign lb_ctl.acc   = acc;
	assign lb_ctl.shift = leave_s1;

	mf3_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lb_ctl),
		.col    (col_q),
		.pix    (pix),
		.win    (win)
	);

	// Split the window into one plane per color.
	always_comb begin
		for (int i = 0; i < WIN_SIZE; i++) begin
			win_b[i] = win[i].blue;
			win_g[i] = win[i].green;
			win_r[i] = win[i].red;
		end
	end

	assign lane_ctl.ld_s3 = rdy_s3;
	assign lane_ctl.ld_s4 = rdy_s4;

	mf3_lane u_lane_blue (
		.clk (clk),
		.ctl (lane_ctl),
		.win (win_b),
		.med (med_b)
	);

	mf3_lane u_lane_green (
		.clk (clk),
		.ctl (lane_ctl),
		.win (win_g),
		.med (med_g)
	);

	mf3_lane u_lane_red (
		.clk (clk),
		.ctl (lane_ctl),
		.win (win_r),
		.med (med_r)
	);

	// Merge the three lane medians with the position into the output register.
	always_ff @(posedge clk) begin
		if (rdy_o) begin
			res_q.out_blue   <= med_b;
			res_q.out_green  <= med_g;
			res_q.out_red    <= med_r;
			res_q.center_row <= meta_s4.center_row;
			res_q.center_col <= meta_s4.center_col;
			res_q.frame_last <= meta_s4.frame_last;
		end
	end

	assign res_valid = v_o;
	assign res       = res_q;

endmodule

@@ rtl/mf3_line_buf.sv @@
// Two line memories and the 3x3 pixel window of the median filter.
// Depends on mf3_pkg for the pixel and window types.
module mf3_line_buf #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mf3_pkg::lb_ctl_t             ctl,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  mf3_pkg::pixel_t              pix,
	output mf3_pkg::win_pix_t            win
);
	import mf3_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	pixel_t upper_mem [MAX_WIDTH];
	pixel_t lower_mem [MAX_WIDTH];

	pixel_t            pix_s1;
	logic [COL_W-1:0]  addr_s1;
	pixel_t            up_s1;
	pixel_t            lo_s1;
	win_pix_t          win_q;

	// Read both rows above the incoming pixel when the item is accepted.
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			up_s1   <= upper_mem[col];
			lo_s1   <= lower_mem[col];
			pix_s1  <= pix;
			addr_s1 <= col;
		end
	end

	// Move the column down one row when the item leaves stage 1.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			upper_mem[addr_s1] <= lo_s1;
			lower_mem[addr_s1] <= pix_s1;
		end
	end

	// Shift the window left by one column and insert the new column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.shift) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= up_s1;
			win_q[5] <= lo_s1;
			win_q[8] <= pix_s1;
		end
	end

	assign win = win_q;

endmodule

@@ rtl/mf3_lane.sv @@
// One color lane of the median filter: median of nine 8-bit values.
// Two register stages; depends on mf3_pkg for the channel and window types.
module mf3_lane (
	input  logic                clk,
	input  mf3_pkg::lane_ctl_t  ctl,
	input  mf3_pkg::win_chan_t  win,
	output mf3_pkg::chan_t      med
);
	import mf3_pkg::*;

	// Three values, index 0 smallest.
	typedef chan_t [2:0] trio_t;

	function automatic trio_t sort3(input chan_t a, input chan_t b, input chan_t c);
		chan_t lo1;
		chan_t hi1;
		chan_t t;
		trio_t r;
		lo1  = (a < b) ? a : b;
		hi1  = (a < b) ? b : a;
		r[0] = (lo1 < c) ? lo1 : c;
		t    = (lo1 < c) ? c : lo1;
		r[1] = (hi1 < t) ? hi1 : t;
		r[2] = (hi1 < t) ? t : hi1;
		return r;
	endfunction

	trio_t [2:0] row_s3;
	trio_t       min_srt;
	trio_t       mid_srt;
	trio_t       max_srt;
	trio_t       fin_srt;
	chan_t       lo_max_s4;
	chan_t       mid_med_s4;
	chan_t       hi_min_s4;

	// Sort each window row.
	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			for (int k = 0; k < 3; k++) begin
				row_s3[k] <= sort3(win[k*3], win[k*3+1], win[k*3+2]);
			end
		end
	end

	// Sort the row minimums, the row medians, the row maximums, and the final three.
	always_comb begin
		min_srt = sort3(row_s3[0][0], row_s3[1][0], row_s3[2][0]);
		mid_srt = sort3(row_s3[0][1], row_s3[1][1], row_s3[2][1]);
		max_srt = sort3(row_s3[0][2], row_s3[1][2], row_s3[2][2]);
		fin_srt = sort3(lo_max_s4, mid_med_s4, hi_min_s4);
	end

	// Largest of the row minimums, median of the row medians, smallest of the maximums.
	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			lo_max_s4  <= min_srt[2];
			mid_med_s4 <= mid_srt[1];
			hi_min_s4  <= max_srt[0];
		end
	end

	// The median of those three is the median of all nine.
	assign med = fin_srt[1];

endmodule

@@ verif/median_filter_3x3_rgb_checker.sv @@
`timescale 1ns / 1ps
// Checker for the 3x3 RGB median filter: follows configuration writes and accepted pixels,
// predicts each window median and compares it with the result items. Depends on mf3_pkg.
module median_filter_3x3_rgb_checker #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	input  logic                           pix_ready,
	input  mf3_pkg::pixel_t                pix,
	input  logic                           res_valid,
	input  logic                           res_ready,
	input  mf3_pkg::result_t               res,
	input  logic                           cfg_we,
	input  mf3_pkg::cfg_reg_t              cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);
	import mf3_pkg::*;

	// Predictor state: size registers, two stored rows, the window and the position.
	logic [11:0] width_reg;
	logic [12:0] height_reg;
	pixel_t      row_two_up [MAX_WIDTH];
	pixel_t      row_one_up [MAX_WIDTH];
	pixel_t      window [WIN_SIZE];
	int unsigned next_col;
	int unsigned next_row;
	result_t     expected_medians [$];
	int          fail_count = 0;
	int          outstanding = 0;

	assign errors  = fail_count;
	assign pending = outstanding;

	// Fifth smallest of nine values, by insertion sort.
	function automatic chan_t median_of_nine(input chan_t vals [WIN_SIZE]);
		chan_t sorted [WIN_SIZE];
		chan_t t;
		sorted = vals;
		for (int i = 1; i < WIN_SIZE; i++) begin
			for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--) begin
				t = sorted[j];
				sorted[j] = sorted[j-1];
				sorted[j-1] = t;
			end
		end
		return sorted[WIN_SIZE/2];
	endfunction

	// Shifts one pixel into the window and line stores, and queues the median it completes.
	task automatic accept_pixel(input pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		pixel_t      above;
		pixel_t      prev;
		chan_t       b_vals [WIN_SIZE];
		chan_t       g_vals [WIN_SIZE];
		chan_t       r_vals [WIN_SIZE];
		result_t     want;
		w = (width_reg < DIM_MIN) ? DIM_MIN : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		h = (height_reg < DIM_MIN) ? DIM_MIN :
			(height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		c = next_col % MAX_WIDTH;
		r = next_row;
		above = row_two_up[c];
		prev  = row_one_up[c];
		for (int k = 0; k < 3; k++) begin
			window[k*3]   = window[k*3+1];
			window[k*3+1] = window[k*3+2];
		end
		window[2] = above;
		window[5] = prev;
		window[8] = px;
		row_two_up[c] = prev;
		row_one_up[c] = px;

		// Only a pixel from row 2 and column 2 on completes a window; its center is one row up and one column left.
		if (r >= 2 && c >= 2) begin
			for (int i = 0; i < WIN_SIZE; i++) begin
				b_vals[i] = window[i].blue;
				g_vals[i] = window[i].green;
				r_vals[i] = window[i].red;
			end
			want.out_blue   = median_of_nine(b_vals);
			want.out_green  = median_of_nine(g_vals);
			want.out_red    = median_of_nine(r_vals);
			want.center_row = ROW_OUT_W'(r - 1);
			want.center_col = COL_OUT_W'(c - 1);
			want.frame_last = (r + 1 >= h) && (c + 1 >= w);
			expected_medians.push_back(want);
		end

		// Advance the position, wrapping at the end of a row and of a frame.
		if (c + 1 >= w) begin
			next_col = 0;
			next_row = (r + 1 >= h) ? 0 : ((r + 1) & 12'hFFF);
		end else begin
			next_col = (c + 1) & 11'h7FF;
		end
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Sample both channels and the register port at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			width_reg  = 12'(WIDTH_RST);
			height_reg = 13'(HEIGHT_RST);
			next_col   = 0;
			next_row   = 0;
			foreach (window[i]) window[i] = '0;
			expected_medians.delete();
		end else begin
			// Any register write restarts the frame.
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					width_reg = cfg_data[11:0];
				end else begin
					height_reg = cfg_data;
				end
				next_col = 0;
				next_row = 0;
			end
			if (pix_valid && pix_ready) begin
				accept_pixel(pix);
			end
			if (res_valid && res_ready) begin
				if (expected_medians.size() == 0) begin
					$error("unexpected result item at row %0d, column %0d",
						res.center_row, res.center_col);
					fail_count++;
				end else begin
					want = expected_medians.pop_front();
					check_field("out_blue", want.out_blue, res.out_blue);
					check_field("out_green", want.out_green, res.out_green);
					check_field("out_red", want.out_red, res.out_red);
					check_field("center_row", want.center_row, res.center_row);
					check_field("center_col", want.center_col, res.center_col);
					check_field("frame_last", want.frame_last, res.frame_last);
				end
			end
		end
		outstanding = expected_medians.size();
	end

endmodule

@@ verif/tb_median_filter_3x3_rgb.sv @@
`timescale 1ns / 1ps
// Testbench top for the 3x3 RGB median filter: drives pixels, size writes and the result
// handshake, and gives the verdict. Depends on mf3_pkg, median_filter_3x3_rgb and median_filter_3x3_rgb_checker.
module tb_median_filter_3x3_rgb;
	import mf3_pkg::*;

	localparam int          MAX_W        = 2048;
	localparam int          MAX_H        = 4096;
	localparam int          RANDOM_ITEMS = 1650;
	localparam int          DRAIN_CYCLES = 10;
	localparam int          HOLD_CYCLES  = 400;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pixel_t                pix       = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	result_t               res;
	logic                  cfg_we    = 1'b0;
	cfg_reg_t              cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	int                    errors;
	int                    pending;
	int unsigned           cycle_cnt = 0;
	bit                    no_gaps   = 1'b0;
	bit                    hold_req  = 1'b0;

	median_filter_3x3_rgb #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	median_filter_3x3_rgb_checker #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	// Run limit.
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("tb_median_filter_3x3_rgb: errors");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off so that the block backs up.
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= no_gaps || ($urandom_range(99) >= 30);
			end
		end
	end

	// Mix of full-range values, the extremes and a narrow band that gives many ties.
	function automatic chan_t random_chan();
		case ($urandom_range(3))
			0, 1:    return chan_t'($urandom_range(255));
			2:       return $urandom_range(1) ? 8'hFF : 8'h00;
			default: return chan_t'($urandom_range(131, 125));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.blue  = random_chan();
		px.green = random_chan();
		px.red   = random_chan();
		return px;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Offers one item after a random gap and returns at the falling edge after acceptance.
	task automatic send_pixel(input pixel_t px);
		while (!no_gaps && $urandom_range(99) < 30) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix       <= px;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering, waits for every expected median, then lets the pipeline empty.
	task automatic wait_idle();
		pix_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int                    sent;
		int                    n;
		int                    which;
		logic [CFG_DATA_W-1:0] w_val;
		logic [CFG_DATA_W-1:0] h_val;
		pixel_t                px;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sizes below the minimum clamp to 3 x 3; two frames check the wrap and the last flag.
		write_reg(REG_IMAGE_WIDTH, 13'd0);
		write_reg(REG_IMAGE_HEIGHT, 13'd0);
		for (int k = 0; k < 18; k++) begin
			if (k < 9) begin
				px.blue  = k[0] ? 8'hFF : 8'h00;
				px.green = chan_t'(k * 31);
				px.red   = chan_t'(255 - k * 31);
			end else begin
				px.blue  = 8'hFF;
				px.green = 8'h00;
				px.red   = k[0] ? 8'hFF : 8'h00;
			end
			send_pixel(px);
		end

		// The top data bit lies outside the width register, so this sets width 5.
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 13'h1005);
		repeat (60) send_pixel(random_pixel());
		sent = 60;

		// Height above the maximum clamps; the result side holds off meanwhile.
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 13'd4);
		write_reg(REG_IMAGE_HEIGHT, 13'd8191);
		hold_req = 1'b1;
		repeat (150) send_pixel(random_pixel());
		sent += 150;

		// Width above the maximum clamps to the full line store; every pixel stays on row 0.
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 13'd4095);
		write_reg(REG_IMAGE_HEIGHT, 13'd0);
		repeat (120) send_pixel(random_pixel());
		sent += 120;

		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 13'd3);
		write_reg(REG_IMAGE_HEIGHT, 13'd4097);
		repeat (100) send_pixel(random_pixel());
		sent += 100;

		// Rewriting the same width mid-frame restarts the frame.
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 13'd3);
		repeat (50) send_pixel(random_pixel());
		sent += 50;

		// A long stretch with no gaps on either side.
		wait_idle();
		no_gaps = 1'b1;
		write_reg(REG_IMAGE_WIDTH, 13'd7);
		write_reg(REG_IMAGE_HEIGHT, 13'd5);
		repeat (300) send_pixel(random_pixel());
		sent += 300;
		no_gaps = 1'b0;

		// Random small sizes, writing one or both registers between bursts.
		while (sent < RANDOM_ITEMS) begin
			n     = $urandom_range(200, 60);
			which = $urandom_range(2);
			w_val = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(2)) :
				CFG_DATA_W'($urandom_range(24, 3));
			h_val = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(2)) :
				CFG_DATA_W'($urandom_range(10, 3));
			wait_idle();
			if (which != 2) write_reg(REG_IMAGE_WIDTH, w_val);
			if (which != 1) write_reg(REG_IMAGE_HEIGHT, h_val);
			repeat (n) send_pixel(random_pixel());
			sent += n;
		end

		wait_idle();
		if (errors == 0) begin
			$display("tb_median_filter_3x3_rgb: clean");
		end else begin
			$display("tb_median_filter_3x3_rgb: errors");
		end
		$finish;
	end

endmodule
